/* src/ztt_pkg.sv */
// shared types and constants for the zobrist transposition table
// no dependencies; used by the table top level and its checker
package ztt_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int BOARD_SIDE    = 6;
    localparam int CELL_COUNT    = BOARD_SIDE * BOARD_SIDE;
    localparam int CELL_W        = $clog2(CELL_COUNT);
    localparam int WORD_COUNT    = CELL_COUNT * 2;
    localparam int WORD_W        = $clog2(WORD_COUNT);
    localparam int KEY_W         = 64;
    localparam int DEPTH_W       = 8;
    localparam int VALUE_W       = 32;
    localparam int KIND_W        = 2;
    localparam int CMD_W         = 2;

    // input beat layout, lowest bit up
    localparam int OWN_LO    = 0;
    localparam int OPP_LO    = OWN_LO + CELL_COUNT;
    localparam int KIND_LO   = OPP_LO + CELL_COUNT;
    localparam int DEPTH_LO  = KIND_LO + KIND_W;
    localparam int SCORE_LO  = DEPTH_LO + DEPTH_W;
    localparam int ALPHA_LO  = SCORE_LO + VALUE_W;
    localparam int BETA_LO   = ALPHA_LO + VALUE_W;
    localparam int WIDX_LO   = BETA_LO + VALUE_W;
    localparam int WVAL_LO   = WIDX_LO + 7;
    localparam int S_USED_W  = WVAL_LO + KEY_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W = VALUE_W;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROBE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BETA  = 2'd2;

    typedef struct packed {
        logic                      valid;
        logic [KEY_W-1:0]          key;
        logic [KIND_W-1:0]         kind;
        logic [DEPTH_W-1:0]        depth;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

endpackage

/* src/ztt_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ztt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/zobrist_transposition_table.sv */
// zobrist-hashed, depth-preferred transposition table for a 6x6 board
// depends on ztt_pkg and ztt_ram (zobrist word store and entry store)
//
//  channel | dir | tuser          | tdata (lowest bit up)
//  --------+-----+----------------+------------------------------------------------
//  s_      | in  | cmd            | own_mask, opp_mask, bound_kind, search_depth,
//          |     |                | score, alpha, beta, word_index, word_value
//  m_      | out | hit            | result_value
//
//  load and unused commands leave the table idle, so s_tready stays high
//  for store and probe the key is built one cell a cycle through the single
//  read port of the zobrist word ram, then the entry ram is read once and a
//  store overwrites the entry only with a greater depth
//  after reset the entry ram is swept, one entry a cycle, with s_tready low
//  a probe result waits in the output register; a later probe stalls only in
//  its output state while that register is still full
module zobrist_transposition_table
    import ztt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // own_mask, opp_mask, bound_kind, search_depth,
                                           // score, alpha, beta, word_index, word_value
    input  logic [CMD_W-1:0]     s_tuser,  // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // result_value
    output logic                 m_tuser   // hit
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HASH_END,
        ST_LOOKUP,
        ST_CHECK,
        ST_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          clr_reg, clr_next;
    logic [CELL_W-1:0]         cell_reg, cell_next;
    logic                      use_reg, use_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic [CELL_COUNT-1:0]     own_reg, own_next;
    logic [CELL_COUNT-1:0]     opp_reg, opp_next;
    logic [KIND_W-1:0]         kind_reg, kind_next;
    logic [DEPTH_W-1:0]        depth_reg, depth_next;
    logic signed [VALUE_W-1:0] score_reg, score_next;
    logic signed [VALUE_W-1:0] alpha_reg, alpha_next;
    logic signed [VALUE_W-1:0] beta_reg, beta_next;
    logic                      hit_reg, hit_next;
    logic signed [VALUE_W-1:0] res_reg, res_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic                      m_tuser_reg, m_tuser_next;
    logic [VALUE_W-1:0]        m_tdata_reg, m_tdata_next;

    logic                      s_fire;
    logic [CMD_W-1:0]          s_cmd;
    logic [WORD_W-1:0]         s_widx;

    logic                      zw_we;
    logic [WORD_W-1:0]         zw_raddr;
    logic [KEY_W-1:0]          zw_rdata;

    logic                      ent_we;
    logic [IDX_W-1:0]          ent_waddr;
    entry_t                    ent_wdata;
    entry_t                    ent_rdata;
    logic                      ent_match;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign s_cmd    = s_tuser;
    assign s_widx   = s_tdata[WIDX_LO +: WORD_W];
    assign zw_we    = s_fire && (s_cmd == CMD_LOAD) && (s_widx < WORD_W'(WORD_COUNT));

    // word for cell c sits at 2c, opponent side at 2c + 1
    assign zw_raddr = {cell_reg, ~own_reg[cell_reg]};

    ztt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (WORD_COUNT)
    ) u_words (
        .clk   (aclk),
        .we    (zw_we),
        .waddr (s_widx),
        .wdata (s_tdata[WVAL_LO +: KEY_W]),
        .raddr (zw_raddr),
        .rdata (zw_rdata)
    );

    ztt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .clk   (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (key_reg[IDX_W-1:0]),
        .rdata (ent_rdata)
    );

    assign ent_match = ent_rdata.valid && (ent_rdata.key == key_reg)
                       && (ent_rdata.depth >= depth_reg);

    always_comb begin
        ent_we          = 1'b0;
        ent_waddr       = key_reg[IDX_W-1:0];
        ent_wdata.valid = 1'b1;
        ent_wdata.key   = key_reg;
        ent_wdata.kind  = kind_reg;
        ent_wdata.depth = depth_reg;
        ent_wdata.value = score_reg;
        if (state_reg == ST_CLEAR) begin
            ent_we    = 1'b1;
            ent_waddr = clr_reg;
            ent_wdata = '0;
        end else if (state_reg == ST_CHECK && cmd_reg == CMD_STORE
                     && depth_reg > ent_rdata.depth) begin
            ent_we = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cell_next     = cell_reg;
        use_next      = use_reg;
        key_next      = key_reg;
        cmd_next      = cmd_reg;
        own_next      = own_reg;
        opp_next      = opp_reg;
        kind_next     = kind_reg;
        depth_next    = depth_reg;
        score_next    = score_reg;
        alpha_next    = alpha_reg;
        beta_next     = beta_reg;
        hit_next      = hit_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire && (s_cmd == CMD_STORE || s_cmd == CMD_PROBE)) begin
                    cmd_next   = s_cmd;
                    own_next   = s_tdata[OWN_LO +: CELL_COUNT];
                    opp_next   = s_tdata[OPP_LO +: CELL_COUNT];
                    kind_next  = s_tdata[KIND_LO +: KIND_W];
                    depth_next = s_tdata[DEPTH_LO +: DEPTH_W];
                    score_next = s_tdata[SCORE_LO +: VALUE_W];
                    alpha_next = s_tdata[ALPHA_LO +: VALUE_W];
                    beta_next  = s_tdata[BETA_LO +: VALUE_W];
                    cell_next  = '0;
                    use_next   = 1'b0;
                    key_next   = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                // fold in the word read for the previous cell
                if (use_reg) begin
                    key_next = key_reg ^ zw_rdata;
                end
                use_next  = own_reg[cell_reg] || opp_reg[cell_reg];
                cell_next = cell_reg + 1'b1;
                if (cell_reg == CELL_W'(CELL_COUNT - 1)) begin
                    state_next = ST_HASH_END;
                end
            end
            ST_HASH_END: begin
                if (use_reg) begin
                    key_next = key_reg ^ zw_rdata;
                end
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                hit_next = 1'b0;
                res_next = '0;
                priority if (ent_match && ent_rdata.kind == KIND_EXACT) begin
                    hit_next = 1'b1;
                    res_next = ent_rdata.value;
                end else if (ent_match && ent_rdata.kind == KIND_ALPHA
                             && ent_rdata.value <= alpha_reg) begin
                    hit_next = 1'b1;
                    res_next = alpha_reg;
                end else if (ent_match && ent_rdata.kind == KIND_BETA
                             && ent_rdata.value >= beta_reg) begin
                    hit_next = 1'b1;
                    res_next = beta_reg;
                end else begin
                    hit_next = 1'b0;
                end
                state_next = (cmd_reg == CMD_PROBE) ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = hit_reg;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cell_reg    <= cell_next;
        use_reg     <= use_next;
        key_reg     <= key_next;
        cmd_reg     <= cmd_next;
        own_reg     <= own_next;
        opp_reg     <= opp_next;
        kind_reg    <= kind_next;
        depth_reg   <= depth_next;
        score_reg   <= score_next;
        alpha_reg   <= alpha_next;
        beta_reg    <= beta_next;
        hit_reg     <= hit_next;
        res_reg     <= res_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* src/ztt_checker.sv */
// port-level checks for the zobrist transposition table, bound to its top level
// depends on ztt_pkg
module ztt_checker
    import ztt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [CMD_W-1:0]     s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // no result beat straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // entry sweep holds off input after reset
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input taken during entry sweep");

    // store and probe keep the input closed while the key is built
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_STORE || s_tuser == CMD_PROBE)
        |=> !s_tready)
        else $error("input taken while hashing");

    // a miss always carries zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with non-zero value");

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

endmodule

bind zobrist_transposition_table ztt_checker u_ztt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
